// ===== sv/cprs_pkg.sv =====
// Shared types, widths and register codes for the column profile run segmenter.
package cprs_pkg;

	localparam int MAX_COLUMNS = 2048;
	localparam int COL_W       = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;

	localparam int PIX_W   = 8;
	localparam int MINW_W  = 11;
	localparam int GAP_W   = 12;
	localparam int XB_W    = 12;
	localparam int START_W = 13;
	localparam int SEGW_W  = 11;
	localparam int CFG_W   = 12;
	localparam int IDX_W   = 3;

	// compare width for run widths against min_run_width
	localparam int CMP_W   = (COL_W > MINW_W) ? COL_W : MINW_W;
	// gap accumulate width, one spare bit for saturation
	localparam int SUM_W   = ((COL_W > GAP_W) ? COL_W : GAP_W) + 1;
	// start position sum width
	localparam int ST_W    = ((COL_W > XB_W) ? COL_W : XB_W) + 1;

	localparam logic [GAP_W-1:0] GAP_MAX  = {GAP_W{1'b1}};
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLUMNS - 1);

	typedef enum logic [IDX_W-1:0] {
		REG_WHITE_LEVEL   = 3'd0,
		REG_MIN_RUN_WIDTH = 3'd1,
		REG_MAX_GAP       = 3'd2,
		REG_HUE_TOL       = 3'd3,
		REG_SAT_TOL       = 3'd4,
		REG_VAL_TOL       = 3'd5,
		REG_X_BASE        = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0]  white_level;
		logic [MINW_W-1:0] min_run_width;
		logic [GAP_W-1:0]  max_gap;
		logic [PIX_W-1:0]  hue_tolerance;
		logic [PIX_W-1:0]  sat_tolerance;
		logic [PIX_W-1:0]  val_tolerance;
		logic [XB_W-1:0]   x_base;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		white_level:   8'd128,
		min_run_width: 11'd1,
		max_gap:       12'd4095,
		hue_tolerance: 8'd255,
		sat_tolerance: 8'd255,
		val_tolerance: 8'd255,
		x_base:        12'd0
	};

	typedef struct packed {
		logic [PIX_W-1:0] hue;
		logic [PIX_W-1:0] saturation;
		logic [PIX_W-1:0] brightness;
	} hsv_t;

	typedef struct packed {
		logic [PIX_W-1:0] column_peak;
		logic [PIX_W-1:0] hue;
		logic [PIX_W-1:0] saturation;
		logic [PIX_W-1:0] brightness;
		logic             last_column;
	} col_item_t;

	typedef struct packed {
		logic               segment_valid;
		logic [START_W-1:0] segment_start;
		logic [SEGW_W-1:0]  segment_width;
		logic               scan_done;
		logic               stopped_early;
	} seg_item_t;

endpackage

// ===== sv/column_profile_run_segmenter.sv =====
// Top level: config registers, column input register and result register.
//
// Column profile run segmenter.
// Column channel: col_valid/col_stall/col_data carry one image column per
// transfer (peak gray level, HSV of the top pixel, last-column flag).
// Result channel: res_valid/res_stall/res_data give exactly one result per
// column, in order: segment flag/start/width, scan_done, stopped_early.
// Config: cfg_we/cfg_index/cfg_data write one register per cycle, no wait;
// unknown indexes are dropped. Write only while the block is empty.
// Each column passes through the column register, then its result through the
// result register. Throughput: one column per cycle while res_stall is low; the
// run/gap update is a single compare-and-add step between the two registers.
// A stalled result holds in the result register while the column register
// still takes one more column; col_stall rises only when both are full.
// Reset (arst_n low) clears both stages, the run state and all config
// registers to their defaults; the scan restarts inside a run at column 0.
// After a last_column result the run state is back at its reset values.
module column_profile_run_segmenter
	import cprs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             col_valid,
	output logic             col_stall,
	input  col_item_t        col_data,
	output logic             res_valid,
	input  logic             res_stall,
	output seg_item_t        res_data,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	cfg_t      cfg_q;
	logic      valid_s1;
	col_item_t item_s1;
	logic      valid_s2;
	seg_item_t res_s2;
	seg_item_t result;
	logic      load_s2;
	logic      col_xfer;

	// register file writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WHITE_LEVEL:   cfg_q.white_level   <= cfg_data[PIX_W-1:0];
				REG_MIN_RUN_WIDTH: cfg_q.min_run_width <= cfg_data[MINW_W-1:0];
				REG_MAX_GAP:       cfg_q.max_gap       <= cfg_data[GAP_W-1:0];
				REG_HUE_TOL:       cfg_q.hue_tolerance <= cfg_data[PIX_W-1:0];
				REG_SAT_TOL:       cfg_q.sat_tolerance <= cfg_data[PIX_W-1:0];
				REG_VAL_TOL:       cfg_q.val_tolerance <= cfg_data[PIX_W-1:0];
				REG_X_BASE:        cfg_q.x_base        <= cfg_data[XB_W-1:0];
				default: ;
			endcase
		end
	end

	// result stage loads when it is empty or being drained this cycle
	assign load_s2   = valid_s1 && (!valid_s2 || !res_stall);
	assign col_stall = valid_s1 && !load_s2;
	assign col_xfer  = col_valid && !col_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (col_xfer) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (col_xfer)
			item_s1 <= col_data;
	end

	cprs_run_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (load_s2),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2)
			res_s2 <= result;
	end

	assign res_valid = valid_s2;
	assign res_data  = res_s2;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> valid_s2)
		else $error("column processed but no result presented");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		col_stall |-> valid_s1 && valid_s2 && res_stall)
		else $error("column stalled with room in the pipeline");

endmodule

// ===== sv/cprs_white_det.sv =====
// White column decision: peak threshold plus color continuity against previous column.
module cprs_white_det
	import cprs_pkg::*;
(
	input  col_item_t item,
	input  hsv_t      prev,
	input  cfg_t      cfg,
	output logic      white
);

	logic [PIX_W-1:0] dh, ds, dv;
	logic             peak_ok, prev_set, color_ok;

	always_comb begin
		dh = (prev.hue > item.hue) ? prev.hue - item.hue : item.hue - prev.hue;
		ds = (prev.saturation > item.saturation) ? prev.saturation - item.saturation
			: item.saturation - prev.saturation;
		dv = (prev.brightness > item.brightness) ? prev.brightness - item.brightness
			: item.brightness - prev.brightness;
		peak_ok  = item.column_peak >= cfg.white_level;
		prev_set = |prev;
		color_ok = (dh < cfg.hue_tolerance) && (ds < cfg.sat_tolerance) &&
			(dv < cfg.val_tolerance);
		white    = peak_ok && (!prev_set || color_ok);
	end

endmodule

// ===== sv/cprs_run_track.sv =====
// Run/gap tracking state and per-column result generation.
module cprs_run_track
	import cprs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  col_item_t item,
	input  cfg_t      cfg,
	output seg_item_t result
);

	logic             inside_q, inside_n;
	logic [COL_W-1:0] begin_q, begin_n;
	logic [GAP_W-1:0] gap_q, gap_n;
	hsv_t             prev_q, prev_n;
	logic [COL_W-1:0] col_q, col_n;
	logic             halted_q, halted_n;

	logic             white;
	logic [COL_W-1:0] w_close, w_last;
	logic [GAP_W-1:0] gap_w, gap_one;
	logic             seg_hit;
	logic [COL_W-1:0] seg_w;
	logic [ST_W-1:0]  start_sum;

	function automatic logic [GAP_W-1:0] gap_sat(input logic [GAP_W-1:0] g,
		input logic [COL_W-1:0] n);
		logic [SUM_W-1:0] s;
		s = SUM_W'(g) + SUM_W'(n);
		return (s > SUM_W'(GAP_MAX)) ? GAP_MAX : s[GAP_W-1:0];
	endfunction

	cprs_white_det u_white (
		.item  (item),
		.prev  (prev_q),
		.cfg   (cfg),
		.white (white)
	);

	always_comb begin
		inside_n = inside_q;
		begin_n  = begin_q;
		gap_n    = gap_q;
		prev_n   = prev_q;
		col_n    = col_q;
		halted_n = halted_q;
		seg_hit  = 1'b0;
		seg_w    = '0;
		w_close  = col_q - begin_q;
		gap_w    = gap_sat(gap_q, w_close);
		gap_one  = gap_sat(gap_q, COL_W'(1));
		w_last   = '0;

		if (!halted_q) begin
			prev_n = '{hue: item.hue, saturation: item.saturation,
				brightness: item.brightness};
			if (inside_q && !white) begin
				inside_n = 1'b0;
				if (CMP_W'(w_close) < CMP_W'(cfg.min_run_width)) begin
					gap_n = gap_w;
				end else begin
					gap_n   = '0;
					seg_hit = 1'b1;
					seg_w   = w_close;
				end
			end else if (!inside_q && white) begin
				begin_n  = col_q;
				inside_n = 1'b1;
			end else if (!inside_q) begin
				gap_n = gap_one;
				if (gap_one > cfg.max_gap && begin_q != '0)
					halted_n = 1'b1;
			end

			// open run closed by end of scan
			w_last = col_q - begin_n;
			if (item.last_column && inside_n &&
				CMP_W'(w_last) >= CMP_W'(cfg.min_run_width)) begin
				seg_hit = 1'b1;
				seg_w   = w_last;
			end

			if (col_q < COL_LAST)
				col_n = col_q + COL_W'(1);
		end

		start_sum = ST_W'(begin_n) + ST_W'(cfg.x_base);

		result.segment_valid = seg_hit;
		result.segment_start = seg_hit ? start_sum[START_W-1:0] : '0;
		result.segment_width = seg_hit ? SEGW_W'(seg_w) : '0;
		result.scan_done     = item.last_column;
		result.stopped_early = halted_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b1;
			begin_q  <= '0;
			gap_q    <= '0;
			prev_q   <= '0;
			col_q    <= '0;
			halted_q <= 1'b0;
		end else if (step) begin
			if (item.last_column) begin
				inside_q <= 1'b1;
				begin_q  <= '0;
				gap_q    <= '0;
				prev_q   <= '0;
				col_q    <= '0;
				halted_q <= 1'b0;
			end else begin
				inside_q <= inside_n;
				begin_q  <= begin_n;
				gap_q    <= gap_n;
				prev_q   <= prev_n;
				col_q    <= col_n;
				halted_q <= halted_n;
			end
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.last_column |=> col_q == '0 && inside_q && !halted_q && gap_q == '0)
		else $error("state not cleared after last column");

	a_begin_le_col: assert property (@(posedge clk) disable iff (!arst_n)
		begin_q <= col_q)
		else $error("run start beyond current column");

	a_no_seg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		step && !result.segment_valid |->
			result.segment_start == '0 && result.segment_width == '0)
		else $error("segment fields nonzero without a segment");

endmodule

// ===== verif/cprs_segment_checker.sv =====
// Checker for the column profile run segmenter: predicts every result and compares it.
`timescale 1ns / 1ps
module cprs_segment_checker
	import cprs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             col_valid,
	input  logic             col_stall,
	input  col_item_t        col_data,
	input  logic             res_valid,
	input  logic             res_stall,
	input  seg_item_t        res_data,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output int               outstanding,
	output int               mismatches
);

	// mirror of the config registers and of the scan state
	cfg_t             cfg = CFG_RESET;
	logic             in_run = 1'b1;
	logic [COL_W-1:0] run_start = '0;
	logic [GAP_W-1:0] gap_len = '0;
	hsv_t             prev_tone = '0;
	logic [COL_W-1:0] col_idx = '0;
	logic             scan_halted = 1'b0;

	seg_item_t        expected_segments[$];
	seg_item_t        want;
	seg_item_t        got;
	int               error_total = 0;

	function automatic void clear_scan();
		in_run      = 1'b1;
		run_start   = '0;
		gap_len     = '0;
		prev_tone   = '0;
		col_idx     = '0;
		scan_halted = 1'b0;
	endfunction

	function automatic int pix_delta(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
		return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	function automatic void gap_grow(input int n);
		int sum;
		sum = int'(gap_len) + n;
		gap_len = (sum > int'(GAP_MAX)) ? GAP_MAX : GAP_W'(sum);
	endfunction

	// one column in, one segment result out; updates the mirrored state
	function automatic seg_item_t segment_column(input col_item_t c);
		seg_item_t r;
		logic      white;
		int        span;
		r = '0;
		if (!scan_halted) begin
			white = (c.column_peak >= cfg.white_level);
			if (prev_tone != '0)
				white = white &&
					(pix_delta(prev_tone.hue, c.hue) < int'(cfg.hue_tolerance)) &&
					(pix_delta(prev_tone.saturation, c.saturation) < int'(cfg.sat_tolerance)) &&
					(pix_delta(prev_tone.brightness, c.brightness) < int'(cfg.val_tolerance));
			prev_tone = '{hue: c.hue, saturation: c.saturation, brightness: c.brightness};

			if (in_run && !white) begin
				span = int'(col_idx) - int'(run_start);
				in_run = 1'b0;
				if (span < int'(cfg.min_run_width)) begin
					gap_grow(span);
				end else begin
					gap_len         = '0;
					r.segment_valid = 1'b1;
					r.segment_start = START_W'(int'(run_start) + int'(cfg.x_base));
					r.segment_width = SEGW_W'(span);
				end
			end else if (!in_run && white) begin
				run_start = col_idx;
				in_run    = 1'b1;
			end else if (!in_run) begin
				gap_grow(1);
				if (gap_len > cfg.max_gap && run_start != '0)
					scan_halted = 1'b1;
			end

			if (c.last_column && in_run) begin
				span = int'(col_idx) - int'(run_start);
				if (span >= int'(cfg.min_run_width)) begin
					r.segment_valid = 1'b1;
					r.segment_start = START_W'(int'(run_start) + int'(cfg.x_base));
					r.segment_width = SEGW_W'(span);
				end
			end

			if (col_idx != COL_LAST)
				col_idx = col_idx + COL_W'(1);
		end
		r.scan_done     = c.last_column;
		r.stopped_early = scan_halted;
		if (c.last_column)
			clear_scan();
		return r;
	endfunction

	task automatic check_field(input string field, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_val, act_val);
			error_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = CFG_RESET;
			clear_scan();
			expected_segments.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WHITE_LEVEL:   cfg.white_level   = cfg_data[PIX_W-1:0];
					REG_MIN_RUN_WIDTH: cfg.min_run_width = cfg_data[MINW_W-1:0];
					REG_MAX_GAP:       cfg.max_gap       = cfg_data[GAP_W-1:0];
					REG_HUE_TOL:       cfg.hue_tolerance = cfg_data[PIX_W-1:0];
					REG_SAT_TOL:       cfg.sat_tolerance = cfg_data[PIX_W-1:0];
					REG_VAL_TOL:       cfg.val_tolerance = cfg_data[PIX_W-1:0];
					REG_X_BASE:        cfg.x_base        = cfg_data[XB_W-1:0];
					default: ;
				endcase
			end

			if (col_valid && !col_stall)
				expected_segments.push_back(segment_column(col_data));

			if (res_valid && !res_stall) begin
				got = res_data;
				if (expected_segments.size() == 0) begin
					$display("%0t: result with no column pending, expected none actual %h",
						$time, got);
					error_total++;
				end else begin
					want = expected_segments.pop_front();
					check_field("segment_valid", want.segment_valid, got.segment_valid);
					check_field("segment_start", want.segment_start, got.segment_start);
					check_field("segment_width", want.segment_width, got.segment_width);
					check_field("scan_done", want.scan_done, got.scan_done);
					check_field("stopped_early", want.stopped_early, got.stopped_early);
				end
			end

			outstanding <= expected_segments.size();
		end
		mismatches <= error_total;
	end

endmodule

// ===== verif/column_profile_run_segmenter_tb.sv =====
// Testbench top for the column profile run segmenter: stimulus, config phases and verdict.
`timescale 1ns / 1ps
module column_profile_run_segmenter_tb;
	import cprs_pkg::*;

	// index past the end of the register list, must be dropped by the block
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int HOLD_CYCLES      = 300;
	localparam int PHASE_COLUMNS    = 125;
	localparam int PHASE_COUNT      = 9;
	localparam int GAP_SCAN_COLUMNS = 160;
	localparam int DRAIN_LIMIT      = 50000;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             col_valid = 1'b0;
	logic             col_stall;
	col_item_t        col_data  = '0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	seg_item_t        res_data;
	logic             cfg_we    = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data  = '0;

	int outstanding;
	int mismatches;

	// idle rates in percent, set per phase by the stimulus
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	// long receiver hold-off: stimulus bumps hold_asks, receiver counts it out
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// shaping state for generated scans
	int   shape_level = 128;
	bit   bright_run  = 1'b1;
	int   run_left    = 0;
	hsv_t tone        = '0;

	column_profile_run_segmenter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.col_valid (col_valid),
		.col_stall (col_stall),
		.col_data  (col_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cprs_segment_checker checker_inst (
		.clk         (clk),
		.arst_n      (arst_n),
		.col_valid   (col_valid),
		.col_stall   (col_stall),
		.col_data    (col_data),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_data    (res_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#3000000;
		$display("TB_ERROR");
		$finish;
	end

	// Result side: random stall, or a counted hold-off when one is asked for.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	function automatic col_item_t column_of(input int peak, input int h, input int s,
			input int v, input bit last);
		col_item_t c;
		c.column_peak = PIX_W'(peak);
		c.hue         = PIX_W'(h);
		c.saturation  = PIX_W'(s);
		c.brightness  = PIX_W'(v);
		c.last_column = last;
		return c;
	endfunction

	// small random drift of one color component, clamped to [0, top]
	function automatic logic [PIX_W-1:0] nudge(input logic [PIX_W-1:0] x, input int d,
			input int top);
		int y;
		y = int'(x) + int'($urandom_range(2 * d)) - d;
		if (y < 0)
			y = 0;
		if (y > top)
			y = top;
		return PIX_W'(y);
	endfunction

	// Next column of a generated scan: alternating bright and dark stretches with
	// slowly drifting color, now and then a color jump, an all-zero color, or pure noise.
	function automatic col_item_t next_column(input bit closing);
		col_item_t c;
		int        d;
		if ($urandom_range(11) == 0) begin
			c.column_peak = PIX_W'($urandom_range(255));
			c.hue         = PIX_W'($urandom_range(255));
			c.saturation  = PIX_W'($urandom_range(255));
			c.brightness  = PIX_W'($urandom_range(255));
			c.last_column = ($urandom_range(3) == 0);
			return c;
		end
		if (run_left == 0) begin
			bright_run = !bright_run;
			run_left   = $urandom_range(1, 9);
		end
		run_left--;
		if (bright_run || shape_level == 0)
			c.column_peak = PIX_W'(shape_level + int'($urandom_range(255 - shape_level)));
		else
			c.column_peak = PIX_W'($urandom_range(shape_level - 1));
		case ($urandom_range(15))
			0: tone = '0;
			1, 2: begin
				tone.hue        = PIX_W'($urandom_range(179));
				tone.saturation = PIX_W'($urandom_range(255));
				tone.brightness = PIX_W'($urandom_range(255));
			end
			default: begin
				d = $urandom_range(8);
				tone.hue        = nudge(tone.hue, d, 179);
				tone.saturation = nudge(tone.saturation, d, 255);
				tone.brightness = nudge(tone.brightness, d, 255);
			end
		endcase
		c.hue         = tone.hue;
		c.saturation  = tone.saturation;
		c.brightness  = tone.brightness;
		c.last_column = closing;
		return c;
	endfunction

	function automatic int random_tolerance();
		case ($urandom_range(3))
			0: return $urandom_range(1, 12);
			1: return $urandom_range(255);
			2: return 255;
			default: return $urandom_range(3, 40);
		endcase
	endfunction

	// One column transfer: optional idle cycles, then hold the payload until taken.
	task automatic send_column(input col_item_t c);
		while ($urandom_range(99) < tx_idle_pct) begin
			col_valid <= 1'b0;
			@(posedge clk);
		end
		col_valid <= 1'b1;
		col_data  <= c;
		@(posedge clk);
		while (col_stall)
			@(posedge clk);
	endtask

	// Stop offering and wait until every pending result has come out, then let the
	// two-stage pipe settle.
	task automatic wait_drained();
		int spin;
		spin = 0;
		col_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 && spin < DRAIN_LIMIT) begin
			@(posedge clk);
			spin++;
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(val);
		@(posedge clk);
	endtask

	// Full register set; the unused index gets random data and must change nothing.
	task automatic program_config(input int wl, input int mrw, input int mg, input int ht,
			input int st, input int vt, input int xb);
		write_reg(REG_WHITE_LEVEL, wl);
		write_reg(REG_MIN_RUN_WIDTH, mrw);
		write_reg(REG_MAX_GAP, mg);
		write_reg(REG_HUE_TOL, ht);
		write_reg(REG_SAT_TOL, st);
		write_reg(REG_VAL_TOL, vt);
		write_reg(REG_X_BASE, xb);
		write_reg(REG_UNUSED, $urandom_range(4095));
		cfg_we      <= 1'b0;
		shape_level = wl;
	endtask

	initial begin
		int ph;
		int k;
		int len;
		int phase_items;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 18;
		rx_idle_pct = 64;

		// Directed, reset config: run open from column 0, closed by a dark column,
		// hue above 179, peak exactly at the level, a hue step of the full
		// tolerance closing a run on the last column, and a lone last column.
		send_column(column_of(255, 0, 0, 0, 1'b0));
		send_column(column_of(255, 179, 255, 255, 1'b0));
		send_column(column_of(0, 179, 255, 255, 1'b0));
		send_column(column_of(127, 255, 0, 0, 1'b0));
		send_column(column_of(128, 255, 0, 0, 1'b0));
		send_column(column_of(255, 0, 0, 0, 1'b1));
		send_column(column_of(255, 0, 0, 0, 1'b1));
		wait_drained();

		// Directed, tight gap limit: a narrow run feeds the gap, the scan halts,
		// halted columns are ignored, then a halt that lands on the last column.
		program_config(128, 3, 0, 255, 255, 255, 0);
		send_column(column_of(0, 10, 10, 10, 1'b0));
		send_column(column_of(200, 10, 10, 10, 1'b0));
		send_column(column_of(200, 10, 10, 10, 1'b0));
		send_column(column_of(0, 10, 10, 10, 1'b0));
		send_column(column_of(0, 10, 10, 10, 1'b0));
		send_column(column_of(255, 10, 10, 10, 1'b0));
		send_column(column_of(255, 10, 10, 10, 1'b1));
		send_column(column_of(0, 20, 20, 20, 1'b0));
		send_column(column_of(255, 20, 20, 20, 1'b0));
		send_column(column_of(0, 20, 20, 20, 1'b0));
		send_column(column_of(0, 20, 20, 20, 1'b1));
		wait_drained();

		// Random phases, each with its own config; every phase ends drained so the
		// next config write finds the block idle.
		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			if (ph < 3) begin
				tx_idle_pct = 18;
				rx_idle_pct = 64;
			end else if (ph < 6) begin
				tx_idle_pct = 64;
				rx_idle_pct = 18;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			case (ph)
				0: program_config(0, 0, 0, 0, 0, 0, 0);
				1: program_config(255, 2047, 4095, 255, 255, 255, 4095);
				2: program_config(255, 1, 3, 255, 255, 255, 4095);
				default: program_config($urandom_range(40, 220),
					($urandom_range(5) == 0) ? $urandom_range(2047) : $urandom_range(6),
					($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(25),
					random_tolerance(), random_tolerance(), random_tolerance(),
					$urandom_range(4095));
			endcase

			// receiver holds off while the sender keeps pushing: input side backs up
			if (ph == 6)
				hold_asks++;

			phase_items = 0;
			while (phase_items < PHASE_COLUMNS) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
				for (k = 0; k < len; k++) begin
					send_column(next_column(k == len - 1));
					phase_items++;
				end
			end
			wait_drained();
		end

		// Long scan: gap grows past max_gap while the run start is still column 0, so
		// no halt; then one bright column opens a narrow run there and the gap halts
		// the scan two columns later.
		program_config(200, 2, 100, 255, 255, 255, 7);
		for (k = 0; k < GAP_SCAN_COLUMNS; k++) begin
			tone.hue        = PIX_W'($urandom_range(179));
			tone.saturation = PIX_W'($urandom_range(255));
			tone.brightness = PIX_W'($urandom_range(255));
			send_column(column_of((k == 0) ? 0 : $urandom_range(199), tone.hue,
				tone.saturation, tone.brightness, 1'b0));
		end
		send_column(column_of(255, tone.hue, tone.saturation, tone.brightness, 1'b0));
		for (k = 0; k < 3; k++)
			send_column(column_of(0, tone.hue, tone.saturation, tone.brightness, 1'b0));
		send_column(column_of(0, tone.hue, tone.saturation, tone.brightness, 1'b1));
		wait_drained();

		if (mismatches == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
